/* hdl/rhdh_pkg.sv */
// Shared types and constants for the Robin Hood double-hash table.
// Used by robin_hood_double_hash_table; no dependencies.
package rhdh_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_BITS        = 32;
  localparam int unsigned DATA_BITS       = 32;
  localparam int unsigned SIZE_W          = 11;
  localparam int unsigned EPOCH_W         = 12;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1021;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_REPLACED = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_HIT      = 3'd3,
    STAT_MISS     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_HASH,
    S_MUL,
    S_ADD,
    S_MOD,
    S_READ,
    S_EVAL,
    S_RESTORE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 func;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data_in;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [DATA_BITS-1:0] data_out;
    logic [SIZE_W-1:0]    occupancy;
  } rsp_t;

endpackage

/* hdl/robin_hood_double_hash_table.sv */
// Robin Hood hash table with double hashing, slots held in RAM.
// Depends on rhdh_pkg and rhdh_ram.
//
//  channel   signals                     direction  payload
//  req       req_valid / req_stall       in         func, key, data_in
//  rsp       rsp_valid / rsp_stall       out        status, data_out, occupancy
//  cfg       cfg_we / cfg_wdata          in         table_size
//
// One item at a time: an accept state, a bit-serial remainder, then a RAM read and
// a compare per probe, then rsp is loaded; a displaced resident is rehashed.
// After reset a clearing pass over all TABLE_DEPTH slots runs before req is taken.
// A failed displacement chain is undone by a sweep over the S slots; every 4095
// chains the undo tags of all TABLE_DEPTH slots are swept. rsp holds one finished transfer
// while the next item runs.
module robin_hood_double_hash_table #(
  parameter int unsigned TABLE_DEPTH = rhdh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  rhdh_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output rhdh_pkg::rsp_t                   rsp,
  input  logic                             cfg_we,
  input  logic [rhdh_pkg::SIZE_W-1:0]      cfg_wdata
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int SW   = $clog2(TABLE_DEPTH + 1);
  localparam int PW   = $clog2(2 * TABLE_DEPTH);
  localparam int BW   = 2 * SW;
  localparam int PRW  = PW + SW;
  localparam int KB   = rhdh_pkg::KEY_BITS;
  localparam int DB   = rhdh_pkg::DATA_BITS;
  localparam int EW   = rhdh_pkg::EPOCH_W;
  localparam int DIVW = (KB > PRW + 1) ? KB : PRW + 1;
  localparam int DCW  = $clog2(DIVW);

  localparam logic [PW-1:0]  PROBE_MAX = PW'(2 * TABLE_DEPTH - 1);
  localparam logic [AW-1:0]  CLR_LAST  = AW'(TABLE_DEPTH - 1);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(DIVW - 1);

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] pc;
    logic [KB-1:0] key;
    logic [DB-1:0] data;
  } slot_t;

  typedef struct packed {
    logic [EW-1:0] tag;
    logic [PW-1:0] pc;
    logic [KB-1:0] key;
    logic [DB-1:0] data;
  } save_t;

  function automatic logic [PW-1:0] inc_pc(input logic [PW-1:0] v);
    inc_pc = (v >= PROBE_MAX) ? PROBE_MAX : v + 1'b1;
  endfunction

  rhdh_pkg::state_t state, state_next;

  logic [rhdh_pkg::SIZE_W-1:0] table_size;
  logic [SW-1:0]   s_cur, s_reg, sm1;
  logic [KB-1:0]   cur_key;
  logic [DB-1:0]   cur_data;
  logic [PW-1:0]   c;
  logic            is_lookup, chain;
  logic [SW-1:0]   idx, step, h, nvis;
  logic [BW-1:0]   budget;
  logic [EW-1:0]   epoch;
  logic [SW-1:0]   occ;
  logic [DIVW-1:0] div_q;
  logic [SW-1:0]   rem_a, rem_b, rem_a_nx, rem_b_nx;
  logic [SW:0]     ta, tb, idx_sum;
  logic [DCW-1:0]  div_cnt;
  logic [PRW-1:0]  prod;
  rhdh_pkg::status_t res_status;
  logic [DB-1:0]   res_data;
  logic [AW-1:0]   clr_cnt;
  logic [SW-1:0]   rs_cnt;
  logic            rs_pend;
  logic [AW-1:0]   rs_addr;

  logic            walk_none, full, r_empty, r_lower, r_equal, r_hit;
  slot_t           main_rd, main_wdata;
  save_t           bk_rd, bk_wdata;
  logic            main_we, main_re, bk_we, bk_re;
  logic [AW-1:0]   main_waddr, main_raddr, bk_waddr, bk_raddr;

  rhdh_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_DEPTH)) u_main (
    .clk, .we(main_we), .waddr(main_waddr), .wdata(main_wdata),
    .re(main_re), .raddr(main_raddr), .rdata(main_rd)
  );

  rhdh_ram #(.WIDTH($bits(save_t)), .DEPTH(TABLE_DEPTH)) u_backup (
    .clk, .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(bk_rd)
  );

  always_comb begin
    if (table_size < 2) begin
      s_cur = SW'(2);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      s_cur = SW'(TABLE_DEPTH);
    end else begin
      s_cur = SW'(table_size);
    end
  end

  assign sm1      = s_reg - 1'b1;
  assign ta       = {rem_a, div_q[DIVW-1]};
  assign tb       = {rem_b, div_q[DIVW-1]};
  assign rem_a_nx = (ta >= {1'b0, s_reg}) ? SW'(ta - {1'b0, s_reg}) : SW'(ta);
  assign rem_b_nx = (tb >= {1'b0, sm1}) ? SW'(tb - {1'b0, sm1}) : SW'(tb);
  assign idx_sum  = {1'b0, idx} + {1'b0, step};

  assign walk_none = (nvis == s_reg) || (budget == '0);
  assign full      = (occ >= s_reg);
  assign r_empty   = !main_rd.valid;
  assign r_lower   = main_rd.valid && (main_rd.pc < c);
  assign r_equal   = main_rd.valid && !(main_rd.pc < c) && (main_rd.key == cur_key);
  assign r_hit     = r_empty || r_lower || r_equal;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rhdh_pkg::S_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = rhdh_pkg::S_IDLE;
      end
      rhdh_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.func == rhdh_pkg::FUNC_INSERT && epoch == '1) begin
            state_next = rhdh_pkg::S_WRAP;
          end else begin
            state_next = rhdh_pkg::S_HASH;
          end
        end
      end
      rhdh_pkg::S_WRAP: begin
        if (clr_cnt == CLR_LAST) state_next = rhdh_pkg::S_HASH;
      end
      rhdh_pkg::S_HASH: begin
        if (div_cnt == DIV_LAST) begin
          state_next = (c == PW'(1)) ? rhdh_pkg::S_READ : rhdh_pkg::S_MUL;
        end
      end
      rhdh_pkg::S_MUL: state_next = rhdh_pkg::S_ADD;
      rhdh_pkg::S_ADD: state_next = rhdh_pkg::S_MOD;
      rhdh_pkg::S_MOD: begin
        if (div_cnt == DIV_LAST) state_next = rhdh_pkg::S_READ;
      end
      rhdh_pkg::S_READ: begin
        if (!walk_none) begin
          state_next = rhdh_pkg::S_EVAL;
        end else if (chain) begin
          state_next = rhdh_pkg::S_RESTORE;
        end else begin
          state_next = rhdh_pkg::S_DONE;
        end
      end
      rhdh_pkg::S_EVAL: begin
        if (!r_hit) begin
          state_next = rhdh_pkg::S_READ;
        end else if (is_lookup) begin
          state_next = rhdh_pkg::S_DONE;
        end else if (!chain && !r_equal && full) begin
          state_next = rhdh_pkg::S_DONE;
        end else if (r_lower) begin
          state_next = rhdh_pkg::S_HASH;
        end else begin
          state_next = rhdh_pkg::S_DONE;
        end
      end
      rhdh_pkg::S_RESTORE: begin
        if (rs_cnt == s_reg && !rs_pend) state_next = rhdh_pkg::S_DONE;
      end
      rhdh_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = rhdh_pkg::S_IDLE;
      end
      default: state_next = rhdh_pkg::S_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    req_stall  = (state != rhdh_pkg::S_IDLE);
    main_we    = 1'b0;
    main_waddr = idx[AW-1:0];
    main_wdata = '{valid: 1'b1, pc: c, key: cur_key, data: cur_data};
    main_re    = 1'b0;
    main_raddr = idx[AW-1:0];
    bk_we      = 1'b0;
    bk_waddr   = idx[AW-1:0];
    bk_wdata   = '{tag: epoch, pc: main_rd.pc, key: main_rd.key, data: main_rd.data};
    bk_re      = 1'b0;
    bk_raddr   = idx[AW-1:0];
    case (state)
      rhdh_pkg::S_CLEAR: begin
        main_we    = 1'b1;
        main_waddr = clr_cnt;
        main_wdata = '0;
        bk_we      = 1'b1;
        bk_waddr   = clr_cnt;
        bk_wdata   = '0;
      end
      rhdh_pkg::S_WRAP: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        bk_wdata = '0;
      end
      rhdh_pkg::S_READ: begin
        main_re = !walk_none;
        bk_re   = !walk_none;
      end
      rhdh_pkg::S_EVAL: begin
        if (!is_lookup) begin
          main_we = r_equal || ((r_empty || r_lower) && (chain || !full));
          if (chain) begin
            bk_we = r_lower && (bk_rd.tag != epoch);
          end else begin
            bk_we        = r_lower && !full;
            bk_wdata.tag = epoch + 1'b1;
          end
        end
      end
      rhdh_pkg::S_RESTORE: begin
        bk_re      = (rs_cnt < s_reg);
        bk_raddr   = rs_cnt[AW-1:0];
        main_we    = rs_pend && (bk_rd.tag == epoch);
        main_waddr = rs_addr;
        main_wdata = '{valid: 1'b1, pc: bk_rd.pc, key: bk_rd.key, data: bk_rd.data};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rhdh_pkg::S_CLEAR;
      table_size <= rhdh_pkg::TABLE_SIZE_RESET;
      occ        <= '0;
      epoch      <= '0;
      clr_cnt    <= '0;
      rs_cnt     <= '0;
      rs_pend    <= 1'b0;
      div_cnt    <= '0;
      chain      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) table_size <= cfg_wdata;

      if (state == rhdh_pkg::S_CLEAR || state == rhdh_pkg::S_WRAP) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (state == rhdh_pkg::S_WRAP && clr_cnt == CLR_LAST) epoch <= '0;
      end else begin
        clr_cnt <= '0;
      end

      if (state == rhdh_pkg::S_HASH || state == rhdh_pkg::S_MOD) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end

      if (state == rhdh_pkg::S_RESTORE) begin
        rs_pend <= (rs_cnt < s_reg);
        if (rs_cnt < s_reg) rs_cnt <= rs_cnt + 1'b1;
      end else begin
        rs_cnt  <= '0;
        rs_pend <= 1'b0;
      end

      if (state == rhdh_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        rhdh_pkg::S_IDLE: begin
          if (req_valid) chain <= 1'b0;
        end
        rhdh_pkg::S_EVAL: begin
          if (r_hit && !is_lookup) begin
            if (r_empty && (chain || !full)) occ <= occ + 1'b1;
            if (r_lower && !chain && !full) begin
              chain <= 1'b1;
              epoch <= epoch + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rs_addr <= rs_cnt[AW-1:0];
    if (state == rhdh_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.status    <= res_status;
      rsp.data_out  <= res_data;
      rsp.occupancy <= rhdh_pkg::SIZE_W'(occ);
    end
    if (state == rhdh_pkg::S_HASH || state == rhdh_pkg::S_MOD) begin
      rem_a <= rem_a_nx;
      rem_b <= rem_b_nx;
      div_q <= {div_q[DIVW-2:0], 1'b0};
    end else begin
      rem_a <= '0;
      rem_b <= '0;
    end
    case (state)
      rhdh_pkg::S_IDLE: begin
        s_reg      <= s_cur;
        cur_key    <= req.key;
        cur_data   <= req.data_in;
        is_lookup  <= (req.func == rhdh_pkg::FUNC_LOOKUP);
        c          <= PW'(1);
        div_q      <= DIVW'(req.key);
        res_data   <= '0;
        res_status <= rhdh_pkg::STAT_INSERTED;
      end
      rhdh_pkg::S_HASH: begin
        nvis <= '0;
        if (!chain && div_cnt == '0) begin
          budget <= is_lookup ? BW'(s_reg) : BW'(s_reg) * BW'(s_reg);
        end
        if (div_cnt == DIV_LAST) begin
          h    <= rem_a_nx;
          idx  <= rem_a_nx;
          step <= rem_b_nx + 1'b1;
        end
      end
      rhdh_pkg::S_MUL: prod <= PRW'(c - 1'b1) * PRW'(step);
      rhdh_pkg::S_ADD: div_q <= DIVW'(h) + DIVW'(prod);
      rhdh_pkg::S_MOD: begin
        if (div_cnt == DIV_LAST) idx <= rem_a_nx;
      end
      rhdh_pkg::S_READ: begin
        if (!walk_none) begin
          budget <= budget - 1'b1;
          nvis   <= nvis + 1'b1;
        end else begin
          res_status <= is_lookup ? rhdh_pkg::STAT_MISS : rhdh_pkg::STAT_FULL;
        end
      end
      rhdh_pkg::S_EVAL: begin
        if (!r_hit) begin
          idx <= (idx_sum >= {1'b0, s_reg}) ? SW'(idx_sum - {1'b0, s_reg}) : SW'(idx_sum);
          c   <= inc_pc(c);
        end else if (is_lookup) begin
          res_status <= r_equal ? rhdh_pkg::STAT_HIT : rhdh_pkg::STAT_MISS;
          res_data   <= r_equal ? main_rd.data : '0;
        end else if (!chain && r_equal) begin
          res_status <= rhdh_pkg::STAT_REPLACED;
        end else if (!chain && full) begin
          res_status <= rhdh_pkg::STAT_FULL;
        end else begin
          res_status <= rhdh_pkg::STAT_INSERTED;
          if (r_lower) begin
            cur_key  <= main_rd.key;
            cur_data <= main_rd.data;
            c        <= inc_pc(main_rd.pc);
            div_q    <= DIVW'(main_rd.key);
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= TABLE_DEPTH) else $error("occupancy above table depth");
  a_chain_insert: assert property (@(posedge clk) disable iff (rst)
    (chain && state != rhdh_pkg::S_IDLE) |-> !is_lookup)
    else $error("displacement chain during lookup");
  a_budget: assert property (@(posedge clk) disable iff (rst)
    (state == rhdh_pkg::S_EVAL) |-> budget == BW'($past(budget) - 1'b1))
    else $error("probe budget not charged");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == rhdh_pkg::S_READ) |-> idx < s_reg) else $error("probe index out of range");
  a_restore_chain: assert property (@(posedge clk) disable iff (rst)
    (state == rhdh_pkg::S_RESTORE) |-> chain) else $error("undo sweep without chain");
`endif

endmodule

/* hdl/rhdh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rhdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
